// ===== design/slgs_pkg.sv =====
package slgs_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 32;

  // Width of the wide multiplier operand and the split point into low and high parts.
  localparam int XW  = 45;
  localparam int LOW = 17;

  typedef struct packed {
    logic               mode;
    logic [5:0]         column;
    logic signed [31:0] boundary_value;
  } item_t;

  typedef struct packed {
    logic [23:0] sweeps;
    logic        converged;
  } result_t;

  typedef enum logic [2:0] {
    CFG_COLS      = 3'd0,
    CFG_ROWS      = 3'd1,
    CFG_BETA_SQ   = 3'd2,
    CFG_INV_CTR   = 3'd3,
    CFG_OMEGA     = 3'd4,
    CFG_TOLERANCE = 3'd5,
    CFG_MAX_SWEEP = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_T,
    S_RD_R,
    S_RD_B,
    S_RD_U,
    S_SETUP,
    S_MLO,
    S_MHI,
    S_MACC,
    S_ROUND,
    S_UPDATE,
    S_CHECK
  } state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_G,
    PH_S,
    PH_T
  } phase_t;

endpackage

// ===== design/sor_laplace_grid_solver_core.sv =====
// SOR Laplace solver. A load item (mode 0) writes one bottom boundary value and leaves
// busy low. A run item (mode 1) clears the interior, sweeps the grid in place until every
// cell settles or the sweep cap is reached, then strobes result_valid for one cycle with
// the sweep count and converged flag; the result cannot be held off, so the receiver must
// take it in that cycle. Every cell goes through four reads of the single grid memory port
// and four passes of the one shared 29x33 multiplier, plus rounding, update and test steps.
// After reset the block stays busy for a clearing pass that zeroes the bottom boundary
// memory; configuration writes are taken at any time.
module sor_laplace_grid_solver_core #(
  parameter int MAX_COLS = slgs_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = slgs_pkg::DEF_MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  slgs_pkg::item_t   item,
  output logic              result_valid,
  output slgs_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int XW  = slgs_pkg::XW;
  localparam int LOW = slgs_pkg::LOW;
  localparam int HW  = XW - LOW;

  // Configuration registers.
  logic [6:0]  cols_in_use;
  logic [5:0]  rows_in_use;
  logic [23:0] beta_sq;
  logic [15:0] inv_center;
  logic [16:0] omega;
  logic [31:0] tolerance;
  logic [23:0] max_sweeps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= 7'd39;
      rows_in_use <= 6'd9;
      beta_sq     <= 24'd65536;
      inv_center  <= 16'd16384;
      omega       <= 17'd65536;
      tolerance   <= 32'd4295;
      max_sweeps  <= 24'd65535;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slgs_pkg::CFG_COLS:      cols_in_use <= cfg_data[6:0];
        slgs_pkg::CFG_ROWS:      rows_in_use <= cfg_data[5:0];
        slgs_pkg::CFG_BETA_SQ:   beta_sq     <= cfg_data[23:0];
        slgs_pkg::CFG_INV_CTR:   inv_center  <= cfg_data[15:0];
        slgs_pkg::CFG_OMEGA:     omega       <= cfg_data[16:0];
        slgs_pkg::CFG_TOLERANCE: tolerance   <= cfg_data;
        slgs_pkg::CFG_MAX_SWEEP: max_sweeps  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  slgs_pkg::state_t state, state_next;
  slgs_pkg::phase_t ph;

  logic [CAW-1:0]     clr_cnt;
  logic [CW-1:0]      nc;
  logic [RW-1:0]      nr;
  logic [CAW-1:0]     c;
  logic [RAW-1:0]     r;
  logic               first;
  logic               all_ok;
  logic [23:0]        sweep;
  logic signed [31:0] t, lv, rv, bv;
  logic signed [XW-1:0] x;
  logic [31:0]        y;
  logic signed [63:0] acc, prod;
  logic signed [47:0] s;
  logic               dbig;
  logic [30:0]        dmag;

  logic accept;
  logic last_c, last_r, settled, sweep_end, cont;

  assign busy   = (state != slgs_pkg::S_IDLE);
  assign accept = start && !busy;
  assign last_c = ((CW + 1)'(c) + (CW + 1)'(1)) >= (CW + 1)'(nc);
  assign last_r = ((RW + 1)'(r) + (RW + 1)'(1)) >= (RW + 1)'(nr);
  assign settled   = !dbig && ($unsigned(acc) > {1'b0, dmag, 32'b0});
  assign sweep_end = last_c && last_r;
  assign cont      = !(all_ok && settled) && (sweep < max_sweeps);

  // Memories.
  logic                 g_we;
  logic [RAW+CAW-1:0]   g_waddr, g_raddr;
  logic [31:0]          g_wdata, g_rdata;
  logic                 b_we;
  logic [CAW-1:0]       b_waddr, b_raddr;
  logic [31:0]          b_wdata, b_rdata;

  slgs_ram #(.WIDTH(32), .DEPTH(1 << (RAW + CAW))) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  slgs_ram #(.WIDTH(32), .DEPTH(1 << CAW)) u_bottom (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // Shared multiplier: the wide operand goes through in a low and a high part.
  logic signed [HW:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [HW+33:0] mul_p;

  always_comb begin
    if (state == slgs_pkg::S_MHI) begin
      mul_a = {x[XW-1], x[XW-1:LOW]};
    end else begin
      mul_a = $signed({(HW + 1 - LOW)'(0), x[LOW-1:0]});
    end
    mul_b = $signed({1'b0, y});
    mul_p = mul_a * mul_b;
  end

  // Round to nearest with ties away from zero, dropping 16 fraction bits.
  logic [63:0]        rmag;
  logic [47:0]        rq;
  logic signed [47:0] rnd;

  always_comb begin
    rmag = acc[63] ? $unsigned(-acc) : $unsigned(acc);
    rq   = 48'((rmag + 64'd32768) >> 16);
    rnd  = acc[63] ? -$signed(rq) : $signed(rq);
  end

  // Cell update with saturation and the change magnitude for the settle test.
  logic signed [48:0] ts;
  logic signed [31:0] nv;
  logic signed [32:0] dd, dabs, t33, tabs;

  always_comb begin
    ts = 49'(t) + 49'(s);
    if (ts > 49'sd2147483647) begin
      nv = 32'sh7FFFFFFF;
    end else if (ts < -49'sd2147483648) begin
      nv = 32'sh80000000;
    end else begin
      nv = ts[31:0];
    end
    dd   = 33'(nv) - 33'(t);
    dabs = dd[32] ? -dd : dd;
    t33  = 33'(t);
    tabs = t33[32] ? -t33 : t33;
  end

  logic signed [32:0] lr, bu;
  logic signed [31:0] uv;

  always_comb begin
    uv = (first || last_r) ? 32'sd0 : $signed(g_rdata);
    lr = 33'(lv) + 33'(rv);
    bu = 33'(bv) + 33'(uv);
  end

  always_comb begin
    g_raddr = {r, c};
    unique case (state)
      slgs_pkg::S_RD_R: g_raddr = {r, c + CAW'(1)};
      slgs_pkg::S_RD_B: g_raddr = {r - RAW'(1), c};
      slgs_pkg::S_RD_U: g_raddr = {r + RAW'(1), c};
      default:          g_raddr = {r, c};
    endcase
    g_we    = (state == slgs_pkg::S_UPDATE);
    g_waddr = {r, c};
    g_wdata = nv;
    b_raddr = c;
    if (state == slgs_pkg::S_CLEAR) begin
      b_we    = 1'b1;
      b_waddr = clr_cnt;
      b_wdata = 32'd0;
    end else begin
      b_we    = accept && !item.mode && (32'(item.column) < MAX_COLS);
      b_waddr = CAW'(item.column);
      b_wdata = item.boundary_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slgs_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      slgs_pkg::S_CLEAR:  if (&clr_cnt) state_next = slgs_pkg::S_IDLE;
      slgs_pkg::S_IDLE:   if (accept && item.mode) state_next = slgs_pkg::S_RD_T;
      slgs_pkg::S_RD_T:   state_next = slgs_pkg::S_RD_R;
      slgs_pkg::S_RD_R:   state_next = slgs_pkg::S_RD_B;
      slgs_pkg::S_RD_B:   state_next = slgs_pkg::S_RD_U;
      slgs_pkg::S_RD_U:   state_next = slgs_pkg::S_SETUP;
      slgs_pkg::S_SETUP:  state_next = slgs_pkg::S_MLO;
      slgs_pkg::S_MLO:    state_next = slgs_pkg::S_MHI;
      slgs_pkg::S_MHI:    state_next = slgs_pkg::S_MACC;
      slgs_pkg::S_MACC: begin
        state_next = (ph == slgs_pkg::PH_T) ? slgs_pkg::S_CHECK : slgs_pkg::S_ROUND;
      end
      slgs_pkg::S_ROUND: begin
        state_next = (ph == slgs_pkg::PH_S) ? slgs_pkg::S_UPDATE : slgs_pkg::S_MLO;
      end
      slgs_pkg::S_UPDATE: state_next = slgs_pkg::S_MLO;
      slgs_pkg::S_CHECK: begin
        if (!sweep_end || cont) begin
          state_next = slgs_pkg::S_RD_T;
        end else begin
          state_next = slgs_pkg::S_IDLE;
        end
      end
      default: state_next = slgs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (state == slgs_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + CAW'(1);
      end
      if (state == slgs_pkg::S_CHECK && sweep_end && !cont) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      slgs_pkg::S_IDLE: begin
        if (cols_in_use == 7'd0) begin
          nc <= CW'(1);
        end else if (32'(cols_in_use) > MAX_COLS) begin
          nc <= CW'(MAX_COLS);
        end else begin
          nc <= CW'(cols_in_use);
        end
        if (rows_in_use == 6'd0) begin
          nr <= RW'(1);
        end else if (32'(rows_in_use) > MAX_ROWS) begin
          nr <= RW'(MAX_ROWS);
        end else begin
          nr <= RW'(rows_in_use);
        end
        r      <= '0;
        c      <= '0;
        lv     <= '0;
        first  <= 1'b1;
        all_ok <= 1'b1;
        sweep  <= 24'd1;
      end
      // The first sweep sees the cleared interior: old values read as zero.
      slgs_pkg::S_RD_R: t  <= first ? 32'sd0 : $signed(g_rdata);
      slgs_pkg::S_RD_B: rv <= (first || last_c) ? 32'sd0 : $signed(g_rdata);
      slgs_pkg::S_RD_U: bv <= (r == '0) ? $signed(b_rdata) : $signed(g_rdata);
      slgs_pkg::S_SETUP: begin
        acc <= 64'(lr) <<< 16;
        x   <= XW'(bu);
        y   <= 32'(beta_sq);
        ph  <= slgs_pkg::PH_A;
      end
      slgs_pkg::S_MLO: prod <= 64'(mul_p);
      slgs_pkg::S_MHI: begin
        acc  <= acc + prod;
        prod <= 64'(mul_p);
      end
      slgs_pkg::S_MACC: acc <= acc + (prod <<< LOW);
      slgs_pkg::S_ROUND: begin
        acc <= '0;
        case (ph)
          slgs_pkg::PH_A: begin
            x  <= XW'(rnd);
            y  <= 32'(inv_center);
            ph <= slgs_pkg::PH_G;
          end
          slgs_pkg::PH_G: begin
            x  <= XW'(rnd - 48'(t));
            y  <= 32'(omega);
            ph <= slgs_pkg::PH_S;
          end
          default: s <= rnd;
        endcase
      end
      slgs_pkg::S_UPDATE: begin
        lv   <= nv;
        dbig <= |dabs[32:31];
        dmag <= dabs[30:0];
        x    <= XW'(tabs);
        y    <= tolerance;
        acc  <= '0;
        ph   <= slgs_pkg::PH_T;
      end
      slgs_pkg::S_CHECK: begin
        all_ok <= all_ok && settled;
        if (!last_c) begin
          c <= c + CAW'(1);
        end else begin
          c  <= '0;
          lv <= '0;
          if (!last_r) begin
            r <= r + RAW'(1);
          end else begin
            r      <= '0;
            first  <= 1'b0;
            all_ok <= 1'b1;
            if (cont) begin
              sweep <= sweep + 24'd1;
            end else begin
              result.sweeps    <= sweep;
              result.converged <= all_ok && settled;
            end
          end
        end
      end
      default: ;
    endcase
  end

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a solve in progress");

  a_unconverged_at_cap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.converged) |-> (result.sweeps >= max_sweeps))
    else $error("solve stopped unconverged before the sweep cap");

  a_sweeps_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.sweeps != 24'd0))
    else $error("solve reported zero sweeps");

  a_run_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && item.mode) |=> busy)
    else $error("run transfer did not start a solve");

endmodule

// ===== design/slgs_ram.sv =====
module slgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
